// ===== rtl/core/slum_pkg.sv =====
`timescale 1ns / 1ps
package slum_pkg;

	localparam int CORES         = 4;
	localparam int WAYS          = 16;
	localparam int SAMPLE_STRIDE = 64;
	localparam int SAMPLED_SETS  = 32;

	localparam int ADDR_W   = 48;
	localparam int CORE_W   = 2;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 32;
	localparam int CYC_W    = 48;
	localparam int IVAL_W   = 32;

	localparam int STRIDE_W    = $clog2(SAMPLE_STRIDE);
	localparam int SET_W       = $clog2(SAMPLED_SETS);
	localparam int ROWS        = CORES * SAMPLED_SETS;
	localparam int ROW_W       = $clog2(ROWS);
	localparam int RANK_W      = $clog2(WAYS);
	localparam int CNT_ENTRIES = CORES * WAYS;
	localparam int CNT_AW      = $clog2(CNT_ENTRIES);

	localparam logic [IVAL_W-1:0]  INTERVAL_RESET = IVAL_W'(5000000);
	localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

	// apb register map
	localparam int   APB_AW               = 3;
	localparam logic REG_REFRESH_INTERVAL = 1'b0;

	typedef logic [WAYS-1:0][ADDR_W-1:0] tag_row_t;

	typedef struct packed {
		logic [WAYS-1:0]             vld;
		logic [WAYS-1:0][RANK_W-1:0] rank;
	} meta_row_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] pos;
	} dir_res_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_LOOK  = 3'b010,
		ST_COUNT = 3'b100
	} state_t;

endpackage

// ===== rtl/core/slum_if.sv =====
`timescale 1ns / 1ps
interface slum_req_if
	import slum_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] block_address;
	logic [CORE_W-1:0] core_id;
	logic              writeback_hit;
	logic [CYC_W-1:0]  cycle_now;

	modport source (output valid, block_address, core_id, writeback_hit, cycle_now,
		input ready);
	modport sink (input valid, block_address, core_id, writeback_hit, cycle_now,
		output ready);
endinterface

interface slum_rsp_if
	import slum_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               sampled;
	logic               hit;
	logic [POS_W-1:0]   hit_position;
	logic [COUNT_W-1:0] position_count;
	logic               refresh_due;

	modport source (output valid, sampled, hit, hit_position, position_count, refresh_due,
		input ready);
	modport sink (input valid, sampled, hit, hit_position, position_count, refresh_due,
		output ready);
endinterface

// ===== rtl/core/slum_dir.sv =====
`timescale 1ns / 1ps
module slum_dir
	import slum_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ROW_W-1:0]  rd_row,
	input  logic              upd_en,
	input  logic [ADDR_W-1:0] addr,
	input  logic              wb,
	output dir_res_t          res
);

	tag_row_t  tag_mem [ROWS];
	meta_row_t meta_mem [ROWS];

	tag_row_t         tag_rd_s1;
	meta_row_t        meta_rd_s1;
	logic [ROW_W-1:0] row_s1;
	logic             row_vld_s1;
	logic [ROWS-1:0]  row_vld_q;

	meta_row_t         cur;
	meta_row_t         nxt;
	tag_row_t          tag_nxt;
	logic [WAYS-1:0]   match;
	logic              found;
	logic              any_free;
	logic [RANK_W-1:0] hit_way;
	logic [RANK_W-1:0] free_way;
	logic [RANK_W-1:0] vic_way;
	logic [RANK_W-1:0] sel;
	logic [RANK_W:0]   limit;
	logic              promote;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tag_rd_s1  <= tag_mem[rd_row];
			meta_rd_s1 <= meta_mem[rd_row];
			row_s1     <= rd_row;
		end
		if (upd_en) begin
			meta_mem[row_s1] <= nxt;
			if (!found) begin
				tag_mem[row_s1] <= tag_nxt;
			end
		end
	end

	// a row never written reads as all invalid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			row_vld_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				row_vld_s1 <= row_vld_q[rd_row];
			end
			if (upd_en) begin
				row_vld_q[row_s1] <= 1'b1;
			end
		end
	end

	always_comb begin
		cur      = row_vld_s1 ? meta_rd_s1 : '0;
		found    = 1'b0;
		any_free = 1'b0;
		hit_way  = '0;
		free_way = '0;
		vic_way  = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = cur.vld[w] && (tag_rd_s1[w] == addr);
			if (match[w]) begin
				found   = 1'b1;
				hit_way = RANK_W'(w);
			end
			if (!cur.vld[w]) begin
				any_free = 1'b1;
				free_way = RANK_W'(w);
			end
			if (cur.rank[w] == RANK_W'(WAYS - 1)) begin
				vic_way = RANK_W'(w);
			end
		end

		priority if (found) begin
			sel   = hit_way;
			limit = {1'b0, cur.rank[hit_way]};
		end else if (any_free) begin
			sel   = free_way;
			limit = (RANK_W + 1)'(WAYS);
		end else begin
			sel   = vic_way;
			limit = {1'b0, cur.rank[vic_way]};
		end
		promote = !found || !wb;

		// unless it is a write-back hit: age valid ways below the limit, selected way becomes most recent
		nxt = cur;
		for (int w = 0; w < WAYS; w++) begin
			if (promote) begin
				if (RANK_W'(w) == sel) begin
					nxt.rank[w] = '0;
					nxt.vld[w]  = 1'b1;
				end else if (cur.vld[w] && ({1'b0, cur.rank[w]} < limit)) begin
					nxt.rank[w] = cur.rank[w] + 1'b1;
				end
			end
		end

		tag_nxt      = tag_rd_s1;
		tag_nxt[sel] = addr;

		res.hit = found;
		res.pos = POS_W'(cur.rank[hit_way]);
	end

endmodule

// ===== rtl/core/slum_cnt.sv =====
`timescale 1ns / 1ps
module slum_cnt
	import slum_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [CNT_AW-1:0]  rd_addr,
	input  logic               bump,
	output logic [COUNT_W-1:0] cnt_new
);

	logic [COUNT_W-1:0]     cnt_mem [CNT_ENTRIES];
	logic [COUNT_W-1:0]     rd_s1;
	logic [CNT_AW-1:0]      addr_s1;
	logic                   vld_s1;
	logic [CNT_ENTRIES-1:0] vld_q;
	logic [COUNT_W-1:0]     cur;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1   <= cnt_mem[rd_addr];
			addr_s1 <= rd_addr;
		end
		if (bump) begin
			cnt_mem[addr_s1] <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
			if (bump) begin
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	// saturating increment
	always_comb begin
		cur     = vld_s1 ? rd_s1 : '0;
		cnt_new = (cur == COUNT_MAX) ? cur : cur + 1'b1;
	end

endmodule

// ===== rtl/core/sampled_lru_utility_monitor_unit.sv =====
`timescale 1ns / 1ps
// result: registered once an item has passed the ST_LOOK and ST_COUNT states
// flow: one item at a time, accepted only in ST_IDLE; directory row read-modify-write,
//   then read-modify-write of the per-core position counter memory,
//   and ST_COUNT holds while a previous result still waits on the result side
// reset: control, row and counter valid flags and last refresh cycle cleared,
//   refresh interval set to 5000000; no clearing pass, items accepted at once
module sampled_lru_utility_monitor_unit
	import slum_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	slum_req_if.sink           req,
	slum_rsp_if.source         rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [IVAL_W-1:0]  pwdata,
	output logic [IVAL_W-1:0]  prdata,
	output logic               pready
);

	state_t state_q;

	logic [IVAL_W-1:0] interval_q;
	logic [CYC_W-1:0]  last_refresh_q;

	logic [ADDR_W-1:0] addr_s1;
	logic [CORE_W-1:0] core_s1;
	logic              wb_s1;
	logic              sampled_s1;
	logic              due_s1;
	logic              hit_s2;
	logic [POS_W-1:0]  pos_s2;

	logic               rsp_valid_q;
	logic               rsp_sampled_q;
	logic               rsp_hit_q;
	logic [POS_W-1:0]   rsp_pos_q;
	logic [COUNT_W-1:0] rsp_count_q;
	logic               rsp_due_q;

	logic               accept;
	logic               sampled_c;
	logic               due_c;
	logic [CYC_W-1:0]   elapsed;
	logic [ROW_W-1:0]   row_c;
	logic [CNT_AW-1:0]  cnt_addr;
	logic               slot_free;
	logic               finish;
	dir_res_t           dres;
	logic [COUNT_W-1:0] cnt_new;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	always_comb begin
		elapsed   = req.cycle_now - last_refresh_q;
		due_c     = (req.cycle_now >= last_refresh_q) && (elapsed >= CYC_W'(interval_q));
		sampled_c = (req.block_address[STRIDE_W-1:0] == '0) && (32'(req.core_id) < CORES);
		row_c     = ROW_W'(req.core_id) * ROW_W'(SAMPLED_SETS)
			+ ROW_W'(req.block_address[STRIDE_W +: SET_W]);
		cnt_addr  = CNT_AW'(core_s1) * CNT_AW'(WAYS) + CNT_AW'(dres.pos);
		slot_free = !rsp_valid_q || rsp.ready;
		finish    = (state_q == ST_COUNT) && slot_free;
	end

	slum_dir u_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_row (row_c),
		.upd_en ((state_q == ST_LOOK) && sampled_s1),
		.addr   (addr_s1),
		.wb     (wb_s1),
		.res    (dres)
	);

	slum_cnt u_cnt (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == ST_LOOK),
		.rd_addr (cnt_addr),
		.bump    (finish && hit_s2),
		.cnt_new (cnt_new)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= req.block_address;
			core_s1    <= req.core_id;
			wb_s1      <= req.writeback_hit;
			sampled_s1 <= sampled_c;
			due_s1     <= due_c;
		end
		if (state_q == ST_LOOK) begin
			hit_s2 <= sampled_s1 && dres.hit;
			pos_s2 <= dres.pos;
		end
		if (finish) begin
			rsp_sampled_q <= sampled_s1;
			rsp_hit_q     <= hit_s2;
			rsp_pos_q     <= hit_s2 ? pos_s2 : '0;
			rsp_count_q   <= hit_s2 ? cnt_new : '0;
			rsp_due_q     <= due_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			rsp_valid_q    <= 1'b0;
			last_refresh_q <= '0;
			interval_q     <= INTERVAL_RESET;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_COUNT;
				end
				ST_COUNT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (accept && due_c) begin
				last_refresh_q <= req.cycle_now;
			end

			if (psel && penable && pwrite && (paddr[APB_AW-1] == REG_REFRESH_INTERVAL)) begin
				interval_q <= pwdata;
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1] == REG_REFRESH_INTERVAL) ? interval_q : '0;

	assign rsp.valid          = rsp_valid_q;
	assign rsp.sampled        = rsp_sampled_q;
	assign rsp.hit            = rsp_hit_q;
	assign rsp.hit_position   = rsp_pos_q;
	assign rsp.position_count = rsp_count_q;
	assign rsp.refresh_due    = rsp_due_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import slum_pkg::*;

	typedef struct packed {
		logic               sampled;
		logic               hit;
		logic [POS_W-1:0]   pos;
		logic [COUNT_W-1:0] count;
		logic               refresh_due;
	} access_result_t;

	localparam int                TAG_POOL  = 24;
	localparam int                ROUNDS    = 6;
	localparam int                ROUND_LEN = 160;
	localparam logic [APB_AW-1:0] IVAL_ADDR = APB_AW'(4 * REG_REFRESH_INTERVAL);

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [IVAL_W-1:0] pwdata;
	logic [IVAL_W-1:0] prdata;
	logic pready;

	slum_req_if req_ch ();
	slum_rsp_if rsp_ch ();

	sampled_lru_utility_monitor_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow directory copy used for prediction
	bit [ADDR_W-1:0]  shadow_addr [ROWS*WAYS];
	bit               shadow_live [ROWS*WAYS];
	bit [RANK_W-1:0]  shadow_age  [ROWS*WAYS];
	bit [COUNT_W-1:0] hit_counts  [CNT_ENTRIES];
	bit [CYC_W-1:0]   refresh_mark;
	bit [IVAL_W-1:0]  refresh_period;

	access_result_t expected_results [$];
	logic [ADDR_W-1:0] tag_pool [TAG_POOL];
	logic [CYC_W-1:0] cyc_clock;
	bit no_idle;
	int errors;
	int n_results;
	int n_sampled;
	int n_hits;
	int n_refresh;
	int n_settings;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("timeout at %0t, %0d results still expected", $time, expected_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] make_addr(input logic [ADDR_W-1:0] upper, input int set);
		make_addr = {upper[ADDR_W-SET_W-STRIDE_W-1:0], SET_W'(set), {STRIDE_W{1'b0}}};
	endfunction

	// age valid ways below limit, then make sel most recent
	function automatic void raise_to_front(input int base, input int sel, input int limit);
		int w;
		for (w = 0; w < WAYS; w++) begin
			if (w != sel && shadow_live[base+w] && int'(shadow_age[base+w]) < limit)
				shadow_age[base+w]++;
		end
		shadow_age[base+sel] = '0;
	endfunction

	function automatic access_result_t predict_access(input logic [ADDR_W-1:0] addr,
		input logic [CORE_W-1:0] core, input logic wb, input logic [CYC_W-1:0] now);
		access_result_t r;
		logic [STRIDE_W+SET_W-1:0] set_bits;
		int base;
		int w;
		int ci;
		int best;
		bit found;
		r = '0;
		if (now >= refresh_mark && now - refresh_mark >= CYC_W'(refresh_period)) begin
			r.refresh_due = 1'b1;
			refresh_mark = now;
		end
		set_bits = addr[STRIDE_W+SET_W-1:0];
		if (set_bits[STRIDE_W-1:0] == '0 && int'(core) < CORES) begin
			r.sampled = 1'b1;
			base = (int'(core) * SAMPLED_SETS + int'(set_bits[STRIDE_W+SET_W-1:STRIDE_W])) * WAYS;
			found = 1'b0;
			for (w = 0; w < WAYS && !found; w++) begin
				if (shadow_live[base+w] && shadow_addr[base+w] == addr) begin
					ci = int'(core) * WAYS + int'(shadow_age[base+w]);
					if (hit_counts[ci] != COUNT_MAX)
						hit_counts[ci]++;
					r.hit = 1'b1;
					r.pos = POS_W'(shadow_age[base+w]);
					r.count = hit_counts[ci];
					if (!wb)
						raise_to_front(base, w, int'(shadow_age[base+w]));
					found = 1'b1;
				end
			end
			if (!found) begin
				best = -1;
				for (w = 0; w < WAYS && best < 0; w++) begin
					if (!shadow_live[base+w])
						best = w;
				end
				if (best >= 0) begin
					shadow_addr[base+best] = addr;
					shadow_live[base+best] = 1'b1;
					raise_to_front(base, best, WAYS);
				end else begin
					best = 0;
					for (w = 1; w < WAYS; w++) begin
						if (shadow_age[base+w] > shadow_age[base+best])
							best = w;
					end
					shadow_addr[base+best] = addr;
					raise_to_front(base, best, int'(shadow_age[base+best]));
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
			errors++;
		end
	endtask

	task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [CORE_W-1:0] core,
		input logic wb, input logic [CYC_W-1:0] now);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.block_address <= addr;
		req_ch.core_id       <= core;
		req_ch.writeback_hit <= wb;
		req_ch.cycle_now     <= now;
		do @(posedge clk); while (!req_ch.ready);
		expected_results.push_back(predict_access(addr, core, wb, now));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_interval();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= IVAL_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		report_mismatch("refresh_interval readback", 64'(refresh_period), 64'(prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_interval(input logic [IVAL_W-1:0] val);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= IVAL_ADDR;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		refresh_period = val;
		n_settings++;
		check_interval();
	endtask

	// result side: compare each item, then hold ready low for a random stall unless no_idle is set
	initial begin : result_checker
		access_result_t exp_r;
		int stall;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, got sampled=%0b hit=%0b",
						$time, rsp_ch.sampled, rsp_ch.hit);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					report_mismatch("sampled", 64'(exp_r.sampled), 64'(rsp_ch.sampled));
					report_mismatch("hit", 64'(exp_r.hit), 64'(rsp_ch.hit));
					report_mismatch("hit_position", 64'(exp_r.pos), 64'(rsp_ch.hit_position));
					report_mismatch("position_count", 64'(exp_r.count), 64'(rsp_ch.position_count));
					report_mismatch("refresh_due", 64'(exp_r.refresh_due), 64'(rsp_ch.refresh_due));
					n_results++;
					n_sampled += exp_r.sampled;
					n_hits    += exp_r.hit;
					n_refresh += exp_r.refresh_due;
				end
				stall = no_idle ? 0 : $urandom_range(0, 12);
				if (stall > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	task automatic test_reset_state();
		check_interval();
	endtask

	task automatic test_directed_access();
		logic [ADDR_W-1:0] tags [17];
		int k;
		for (k = 0; k < 17; k++)
			tags[k] = make_addr(ADDR_W'(k + 1) * ADDR_W'(48'h9E37_79B9), 5);
		no_idle = 1'b0;
		// first fill, write-back hit, normal hit
		send_access('0, 2'd0, 1'b0, 48'd0);
		send_access('0, 2'd0, 1'b1, 48'd1);
		send_access('0, 2'd0, 1'b0, 48'd2);
		// unsampled set at the refresh boundary, then cycle going backwards
		send_access('1, 2'd3, 1'b1, 48'd5000000);
		send_access(48'hFFFF_FFFF_FFC0, 2'd3, 1'b0, 48'd4999999);
		for (k = 0; k < WAYS; k++)
			send_access(tags[k], 2'd1, 1'b0, 48'd5000001 + k);
		// hit at the least-recent position, eviction, write-back hit at the tail
		send_access(tags[0], 2'd1, 1'b0, 48'd5000020);
		send_access(tags[16], 2'd1, 1'b0, 48'd5000021);
		send_access(tags[2], 2'd1, 1'b1, 48'd5000022);
		send_access(tags[1], 2'd1, 1'b0, 48'd5000023);
		send_access(tags[3], 2'd2, 1'b0, 48'd5000024);
		cyc_clock = 48'd5000025;
	endtask

	task automatic test_interval_extremes();
		no_idle = 1'b1;
		write_interval(32'd1);
		send_access('0, 2'd0, 1'b0, cyc_clock);
		send_access('0, 2'd0, 1'b0, cyc_clock);
		cyc_clock += 1;
		send_access('0, 2'd0, 1'b1, cyc_clock);
		cyc_clock += 2;
		send_access('0, 2'd0, 1'b0, cyc_clock);
		// zero interval: due on every step that does not go backwards
		write_interval(32'd0);
		send_access('0, 2'd0, 1'b0, cyc_clock);
		send_access('0, 2'd0, 1'b0, cyc_clock);
		send_access('0, 2'd0, 1'b0, cyc_clock - 1);
		write_interval('1);
		send_access('0, 2'd1, 1'b0, refresh_mark + 48'hFFFF_FFFE);
		cyc_clock = refresh_mark + 48'hFFFF_FFFF;
		send_access('0, 2'd1, 1'b0, cyc_clock);
	endtask

	task automatic test_random_traffic();
		logic [IVAL_W-1:0] ivals [ROUNDS];
		logic [ADDR_W-1:0] addr;
		logic [CYC_W-1:0] now;
		int round;
		int k;
		int kind;
		int placed;
		ivals[0] = IVAL_W'($urandom_range(1, 100));
		ivals[1] = '1;
		ivals[2] = IVAL_W'(1);
		ivals[3] = IVAL_W'($urandom_range(100, 2000));
		ivals[4] = '0;
		ivals[5] = INTERVAL_RESET;
		for (round = 0; round < ROUNDS; round++) begin
			// the write waits until every result is back
			write_interval(ivals[round]);
			no_idle = (round == 2);
			for (k = 0; k < TAG_POOL; k++)
				tag_pool[k] = ADDR_W'({$urandom, $urandom});
			if (round == 3)
				cyc_clock = {1'b1, 15'($urandom), 32'($urandom)};
			placed = 0;
			while (placed < ROUND_LEN) begin
				kind = $urandom_range(0, 9);
				if (kind == 0)
					addr = ADDR_W'({$urandom, $urandom});
				else if (kind == 1)
					addr = make_addr(ADDR_W'({$urandom, $urandom}), $urandom_range(0, SAMPLED_SETS-1));
				else
					addr = make_addr(tag_pool[$urandom_range(0, TAG_POOL-1)],
						($urandom_range(0, 7) == 0) ? $urandom_range(0, SAMPLED_SETS-1)
							: $urandom_range(0, 3));
				if ($urandom_range(0, 49) == 0 && cyc_clock > 1000) begin
					now = cyc_clock - $urandom_range(1, 1000);
				end else begin
					cyc_clock += $urandom_range(0, 20);
					now = cyc_clock;
				end
				send_access(addr, CORE_W'($urandom_range(0, CORES-1)),
					$urandom_range(0, 3) == 0, now);
				if (addr[STRIDE_W-1:0] == '0)
					placed++;
			end
		end
		send_access('1 << STRIDE_W, 2'd3, 1'b1, '1);
	endtask

	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		req_ch.valid  <= 1'b0;
		req_ch.block_address <= '0;
		req_ch.core_id       <= '0;
		req_ch.writeback_hit <= 1'b0;
		req_ch.cycle_now     <= '0;
		rsp_ch.ready  <= 1'b1;
		refresh_period = INTERVAL_RESET;
		refresh_mark   = '0;
		cyc_clock      = '0;
		no_idle        = 1'b0;
		errors         = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed_access();
		test_interval_extremes();
		test_random_traffic();

		wait_drained();
		repeat (6) @(posedge clk);
		$display("checked %0d accesses: %0d on monitored sets, %0d shadow hits, %0d refresh flags",
			n_results, n_sampled, n_hits, n_refresh);
		$display("refresh interval written %0d times, including 0, 1 and the maximum", n_settings);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
